// ----- hw/rtl/sob_pkg.sv -----
// shared types and constants for the segment/box occlusion test
`timescale 1ns / 1ps
package sob_pkg;

  localparam int CW = 24;          // coordinate width
  localparam int PW = 2 * CW;      // product and quotient width
  localparam int NW = 4;           // walls: left, right, bottom, top

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t seg_ax;
    coord_t seg_ay;
    coord_t seg_bx;
    coord_t seg_by;
    coord_t box_xmin;
    coord_t box_xmax;
    coord_t box_ymin;
    coord_t box_ymax;
  } in_t;

  typedef struct packed {
    logic       blocked;
    logic [1:0] decided_by;
  } out_t;

  // per-wall side information that rides along with the divider
  typedef struct packed {
    logic   act;
    logic   neg;
    coord_t av;
    coord_t lo;
    coord_t hi;
  } lane_t;

  // early decision that rides along with the divider
  typedef struct packed {
    logic corner;
    logic span;
  } early_t;

  localparam logic [1:0] DEC_CORNER = 2'd0;
  localparam logic [1:0] DEC_SPAN   = 2'd1;
  localparam logic [1:0] DEC_WALL   = 2'd2;
  localparam logic [1:0] DEC_CLEAR  = 2'd3;

endpackage

// ----- hw/rtl/sob_prep.sv -----
// front stages: region tests, wall setup, magnitude product
`timescale 1ns / 1ps
module sob_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  sob_pkg::in_t    in_item,
  output logic            valid,
  output logic [sob_pkg::PW-1:0] prod [sob_pkg::NW],
  output logic [sob_pkg::CW-1:0] dvsr [sob_pkg::NW],
  output sob_pkg::lane_t  sb [sob_pkg::NW],
  output sob_pkg::early_t early
);

  localparam int CW = sob_pkg::CW;
  localparam int NW = sob_pkg::NW;

  sob_pkg::coord_t ax, ay, bx, by, xl, xh, yl, yh;
  logic x_out, y_out, x_in, y_in;

  sob_pkg::coord_t w [NW];
  sob_pkg::coord_t au [NW];
  sob_pkg::coord_t av [NW];
  sob_pkg::coord_t bu [NW];
  sob_pkg::coord_t bv [NW];
  sob_pkg::coord_t lo [NW];
  sob_pkg::coord_t hi [NW];
  logic signed [CW:0] n [NW];
  logic signed [CW:0] dv [NW];
  logic signed [CW:0] du [NW];
  logic signed [CW:0] n_abs [NW];
  logic signed [CW:0] dv_abs [NW];
  logic signed [CW:0] du_abs [NW];
  sob_pkg::lane_t sb_c [NW];

  // stage 1 registers
  logic            v1;
  logic [CW-1:0]   mn [NW];
  logic [CW-1:0]   mdv [NW];
  logic [CW-1:0]   mdu [NW];
  sob_pkg::lane_t  sb1 [NW];
  sob_pkg::early_t early1;

  always_comb begin
    ax = in_item.seg_ax;
    ay = in_item.seg_ay;
    bx = in_item.seg_bx;
    by = in_item.seg_by;
    xl = in_item.box_xmin;
    xh = in_item.box_xmax;
    yl = in_item.box_ymin;
    yh = in_item.box_ymax;
    x_out = (ax < xl && bx < xl) || (ax > xh && bx > xh);
    y_out = (ay < yl && by < yl) || (ay > yh && by > yh);
    x_in  = ax >= xl && ax <= xh && bx >= xl && bx <= xh;
    y_in  = ay >= yl && ay <= yh && by >= yl && by <= yh;
  end

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      if (k < 2) begin
        w[k]  = (k == 0) ? xl : xh;
        au[k] = ax; av[k] = ay; bu[k] = bx; bv[k] = by;
        lo[k] = yl; hi[k] = yh;
      end else begin
        w[k]  = (k == 2) ? yl : yh;
        au[k] = ay; av[k] = ax; bu[k] = by; bv[k] = bx;
        lo[k] = xl; hi[k] = xh;
      end
      n[k]  = {w[k][CW-1], w[k]} - {au[k][CW-1], au[k]};
      dv[k] = {av[k][CW-1], av[k]} - {bv[k][CW-1], bv[k]};
      du[k] = {au[k][CW-1], au[k]} - {bu[k][CW-1], bu[k]};
      n_abs[k]  = n[k][CW]  ? -n[k]  : n[k];
      dv_abs[k] = dv[k][CW] ? -dv[k] : dv[k];
      du_abs[k] = du[k][CW] ? -du[k] : du[k];
      sb_c[k].act = (du[k] != '0) &&
                    ((w[k] >= au[k] && w[k] <= bu[k]) || (w[k] >= bu[k] && w[k] <= au[k]));
      sb_c[k].neg = (n[k][CW] ^ dv[k][CW] ^ du[k][CW]) && (n[k] != '0) && (dv[k] != '0);
      sb_c[k].av  = av[k];
      sb_c[k].lo  = lo[k];
      sb_c[k].hi  = hi[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      early1.corner <= x_out && y_out;
      early1.span   <= (x_in && !y_out) || (y_in && !x_out);
      early         <= early1;
      for (int k = 0; k < NW; k++) begin
        mn[k]   <= n_abs[k][CW-1:0];
        mdv[k]  <= dv_abs[k][CW-1:0];
        mdu[k]  <= du_abs[k][CW-1:0];
        sb1[k]  <= sb_c[k];
        // magnitudes fit in CW bits, so the product fits in PW bits
        prod[k] <= mn[k] * mdv[k];
        dvsr[k] <= (mdu[k] == '0) ? CW'(1) : mdu[k];
        sb[k]   <= sb1[k];
      end
    end
  end

endmodule

// ----- hw/rtl/sob_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module sob_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [sob_pkg::PW-1:0] dividend,
  input  logic [sob_pkg::CW-1:0] divisor,
  input  sob_pkg::lane_t         in_sb,
  output logic                   out_valid,
  output logic [sob_pkg::PW-1:0] quot,
  output sob_pkg::lane_t         out_sb
);

  localparam int CW = sob_pkg::CW;
  localparam int PW = sob_pkg::PW;

  logic           s_v  [PW+1];
  logic [CW-1:0]  s_r  [PW+1];
  logic [PW-1:0]  s_nq [PW+1];   // dividend shifts out the top, quotient in at the bottom
  logic [CW-1:0]  s_d  [PW+1];
  sob_pkg::lane_t s_sb [PW+1];

  assign s_v[0]  = in_valid;
  assign s_r[0]  = '0;
  assign s_nq[0] = dividend;
  assign s_d[0]  = divisor;
  assign s_sb[0] = in_sb;

  for (genvar i = 0; i < PW; i++) begin : g_stage
    logic [CW:0]   trial;
    logic [CW+1:0] diff;
    logic          ge;

    assign trial = {s_r[i], s_nq[i][PW-1]};
    assign diff  = {1'b0, trial} - {2'b00, s_d[i]};
    assign ge    = !diff[CW+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[i+1] <= 1'b0;
      end else if (en) begin
        s_v[i+1] <= s_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i+1]  <= ge ? diff[CW-1:0] : trial[CW-1:0];
        s_nq[i+1] <= {s_nq[i][PW-2:0], ge};
        s_d[i+1]  <= s_d[i];
        s_sb[i+1] <= s_sb[i];
      end
    end
  end

  assign out_valid = s_v[PW];
  assign quot      = s_nq[PW];
  assign out_sb    = s_sb[PW];

endmodule

// ----- hw/rtl/segment_box_occlusion_test_core.sv -----
// top level of the segment/box occlusion test pipeline
`timescale 1ns / 1ps
// Tests one 2D segment against one axis-aligned box and returns blocked plus
// the check that decided it. A new transaction is taken every cycle while the
// output is free or being taken; each result passes through two setup stages,
// one stage per quotient bit of the 48-bit crossing divide in four parallel
// wall dividers, and one decision/output register.
// Results leave in input order; a stall on the output holds the whole pipe.
module segment_box_occlusion_test_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sob_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output sob_pkg::out_t out_item
);

  localparam int CW = sob_pkg::CW;
  localparam int PW = sob_pkg::PW;
  localparam int NW = sob_pkg::NW;

  logic            en;
  logic            p_valid;
  logic [PW-1:0]   prod [NW];
  logic [CW-1:0]   dvsr [NW];
  sob_pkg::lane_t  sb_in [NW];
  sob_pkg::lane_t  sb_out [NW];
  logic [PW-1:0]   quot [NW];
  logic [NW-1:0]   d_valid;
  sob_pkg::early_t early_p;
  sob_pkg::early_t early_d [PW+1];
  logic [NW-1:0]   hit;
  sob_pkg::out_t   res;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  sob_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_item),
    .valid    (p_valid),
    .prod     (prod),
    .dvsr     (dvsr),
    .sb       (sb_in),
    .early    (early_p)
  );

  for (genvar k = 0; k < NW; k++) begin : g_wall
    logic signed [PW+1:0] avx, qx, c, lox, hix;

    sob_div u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (p_valid),
      .dividend  (prod[k]),
      .divisor   (dvsr[k]),
      .in_sb     (sb_in[k]),
      .out_valid (d_valid[k]),
      .quot      (quot[k]),
      .out_sb    (sb_out[k])
    );

    assign avx = {{(PW+2-CW){sb_out[k].av[CW-1]}}, sb_out[k].av};
    assign lox = {{(PW+2-CW){sb_out[k].lo[CW-1]}}, sb_out[k].lo};
    assign hix = {{(PW+2-CW){sb_out[k].hi[CW-1]}}, sb_out[k].hi};
    assign qx  = {2'b00, quot[k]};
    assign c   = sb_out[k].neg ? avx - qx : avx + qx;
    assign hit[k] = sb_out[k].act && c >= lox && c <= hix;
  end

  // early decision delayed to match the dividers
  assign early_d[0] = early_p;
  for (genvar i = 0; i < PW; i++) begin : g_early
    always_ff @(posedge clk) begin
      if (en) begin
        early_d[i+1] <= early_d[i];
      end
    end
  end

  always_comb begin
    if (early_d[PW].corner) begin
      res.blocked    = 1'b0;
      res.decided_by = sob_pkg::DEC_CORNER;
    end else if (early_d[PW].span) begin
      res.blocked    = 1'b1;
      res.decided_by = sob_pkg::DEC_SPAN;
    end else if (|hit) begin
      res.blocked    = 1'b1;
      res.decided_by = sob_pkg::DEC_WALL;
    end else begin
      res.blocked    = 1'b0;
      res.decided_by = sob_pkg::DEC_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= res;
    end
  end

endmodule

// ----- hw/rtl/sob_checker.sv -----
// port-level checks for the occlusion test core, bound to the top level
`timescale 1ns / 1ps
module sob_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input sob_pkg::out_t out_item,
  input logic          out_valid,
  input logic          out_ready
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // input side stalls exactly when a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output side");

  // blocked agrees with the deciding check
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.blocked ==
      (out_item.decided_by == sob_pkg::DEC_SPAN || out_item.decided_by == sob_pkg::DEC_WALL))
    else $error("blocked inconsistent with decided_by");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind segment_box_occlusion_test_core sob_checker u_sob_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_item  (out_item),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
